// File: hdl/root_support_mode_arbiter_assert.svh
// Assertion macros for the root support mode arbiter.
// Depends on nothing; the including module supplies clock and reset.
`ifndef ROOT_SUPPORT_MODE_ARBITER_ASSERT_SVH
`define ROOT_SUPPORT_MODE_ARBITER_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define RSMA_ASSERT_IMP(label, cond, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error("rsma: same-cycle check failed");
// Next-cycle implication, checked out of reset.
`define RSMA_ASSERT_NXT(label, cond, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error("rsma: next-cycle check failed");
`else
`define RSMA_ASSERT_IMP(label, cond, prop)
`define RSMA_ASSERT_NXT(label, cond, prop)
`endif
`endif

// File: hdl/rsma_pkg.sv
// Package for the root support mode arbiter: widths, support and posture
// codes, register indexes and confidence constants. Depends on nothing.
`default_nettype none
package rsma_pkg;

   localparam int KIND_W    = 3;
   localparam int POSTURE_W = 3;
   localparam int CONF_W    = 16;
   localparam int TIME_W    = 32;
   localparam int DT_W      = 16;
   localparam int HOLD_W    = 24;
   localparam int POS_W     = 32;
   localparam int QUAT_W    = 16;
   localparam int CSR_IDX_W = 1;

   typedef logic [KIND_W-1:0] kind_type;

   localparam kind_type KIND_NONE  = 3'd0;
   localparam kind_type KIND_FEET  = 3'd1;
   localparam kind_type KIND_KNEE  = 3'd2;
   localparam kind_type KIND_MIXED = 3'd3;
   localparam kind_type KIND_SEAT  = 3'd4;
   localparam kind_type KIND_REST  = 3'd5;

   localparam logic [POSTURE_W-1:0] POSTURE_SEATED     = 3'd0;
   localparam logic [POSTURE_W-1:0] POSTURE_RECLINED   = 3'd1;
   localparam logic [POSTURE_W-1:0] POSTURE_KNEELING   = 3'd2;
   localparam logic [POSTURE_W-1:0] POSTURE_CROUCHING  = 3'd3;
   localparam logic [POSTURE_W-1:0] POSTURE_STANDING   = 3'd4;
   localparam logic [POSTURE_W-1:0] POSTURE_TRANSITION = 3'd5;

   localparam logic [CSR_IDX_W-1:0] CSR_RELEASE_TIME    = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TRANSITION_HOLD = 1'd1;

   localparam logic [HOLD_W-1:0] RELEASE_TIME_RESET    = 24'd16384;
   localparam logic [HOLD_W-1:0] TRANSITION_HOLD_RESET = 24'd32768;

   // Confidence of one and the 0.35 restart value, both Q1.15.
   localparam logic [CONF_W-1:0] CONF_ONE     = 16'd32768;
   localparam logic [CONF_W-1:0] CONF_RESTART = 16'd11469;

endpackage
`default_nettype wire

// File: hdl/root_support_mode_arbiter.sv
// Root support mode arbiter: one frame per transfer updates the support type
// and the root anchor. Depends on rsma_pkg and root_support_mode_arbiter_assert.svh.
// A request transfer makes the response valid in the next cycle.
// Throughput: one frame per cycle; the anchor state registers double as the
// response register, and a new frame is taken when that register is empty
// or is being drained in the same cycle.
// Reset (synchronous): support none, anchor cleared, timers and pose zero,
// hold registers at 0.25 s and 0.5 s, no response pending.
`default_nettype none
`include "root_support_mode_arbiter_assert.svh"
module root_support_mode_arbiter (
   input  wire                                   clock,
   input  wire                                   reset,
   // Configuration writes.
   input  wire                                   csr_valid,
   output logic                                  csr_ready,
   input  wire  [rsma_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire  [rsma_pkg::HOLD_W-1:0]           csr_data,
   // Frame requests.
   input  wire                                   req_valid,
   output logic                                  req_ready,
   input  wire  [rsma_pkg::POSTURE_W-1:0]        req_posture_mode,
   input  wire                                   req_any_foot_active,
   input  wire                                   req_any_knee_active,
   input  wire  [rsma_pkg::DT_W-1:0]             req_frame_time,
   input  wire  signed [rsma_pkg::POS_W-1:0]     req_root_pos_x,
   input  wire  signed [rsma_pkg::POS_W-1:0]     req_root_pos_y,
   input  wire  signed [rsma_pkg::POS_W-1:0]     req_root_pos_z,
   input  wire  signed [rsma_pkg::QUAT_W-1:0]    req_root_quat_w,
   input  wire  signed [rsma_pkg::QUAT_W-1:0]    req_root_quat_x,
   input  wire  signed [rsma_pkg::QUAT_W-1:0]    req_root_quat_y,
   input  wire  signed [rsma_pkg::QUAT_W-1:0]    req_root_quat_z,
   // Anchor responses.
   output logic                                  rsp_valid,
   input  wire                                   rsp_ready,
   output logic [rsma_pkg::KIND_W-1:0]           rsp_support_kind,
   output logic                                  rsp_anchor_on,
   output logic [rsma_pkg::CONF_W-1:0]           rsp_anchor_confidence,
   output logic [rsma_pkg::TIME_W-1:0]           rsp_anchor_dwell,
   output logic signed [rsma_pkg::POS_W-1:0]     rsp_anchor_pos_x,
   output logic signed [rsma_pkg::POS_W-1:0]     rsp_anchor_pos_y,
   output logic signed [rsma_pkg::POS_W-1:0]     rsp_anchor_pos_z,
   output logic signed [rsma_pkg::QUAT_W-1:0]    rsp_anchor_quat_w,
   output logic signed [rsma_pkg::QUAT_W-1:0]    rsp_anchor_quat_x,
   output logic signed [rsma_pkg::QUAT_W-1:0]    rsp_anchor_quat_y,
   output logic signed [rsma_pkg::QUAT_W-1:0]    rsp_anchor_quat_z
);

   // Hold time registers.
   logic [rsma_pkg::HOLD_W-1:0] release_time_ff;
   logic [rsma_pkg::HOLD_W-1:0] transition_hold_ff;

   // Anchor state; also the response payload.
   rsma_pkg::kind_type          support_ff, support_in;
   logic                        active_ff, active_in;
   logic [rsma_pkg::CONF_W-1:0] conf_ff, conf_in;
   logic [rsma_pkg::TIME_W-1:0] dwell_ff, dwell_in;
   logic [rsma_pkg::TIME_W-1:0] release_ff, release_in;
   logic                        latch_pose;
   logic signed [rsma_pkg::POS_W-1:0]  pos_x_ff, pos_y_ff, pos_z_ff;
   logic signed [rsma_pkg::QUAT_W-1:0] quat_w_ff, quat_x_ff, quat_y_ff, quat_z_ff;
   logic                        rsp_valid_ff, rsp_valid_in;

   logic                        req_xfer;
   rsma_pkg::kind_type          desired;
   logic [rsma_pkg::HOLD_W-1:0] hold;
   logic [rsma_pkg::TIME_W:0]   dwell_sum;
   logic [rsma_pkg::TIME_W:0]   release_sum;
   logic [rsma_pkg::TIME_W-1:0] release_sat;
   logic [rsma_pkg::CONF_W:0]   conf_sum;

   assign csr_ready = 1'b1;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_xfer  = req_valid && req_ready;

   // Configuration write.
   always_ff @(posedge clock) begin
      if (reset) begin
         release_time_ff    <= rsma_pkg::RELEASE_TIME_RESET;
         transition_hold_ff <= rsma_pkg::TRANSITION_HOLD_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            rsma_pkg::CSR_RELEASE_TIME:    release_time_ff    <= csr_data;
            rsma_pkg::CSR_TRANSITION_HOLD: transition_hold_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Desired support type from posture and contact flags.
   always_comb begin
      unique case (req_posture_mode)
         rsma_pkg::POSTURE_SEATED:   desired = rsma_pkg::KIND_SEAT;
         rsma_pkg::POSTURE_RECLINED: desired = rsma_pkg::KIND_REST;
         rsma_pkg::POSTURE_KNEELING,
         rsma_pkg::POSTURE_CROUCHING: begin
            if (req_any_foot_active && req_any_knee_active) desired = rsma_pkg::KIND_MIXED;
            else if (req_any_knee_active) desired = rsma_pkg::KIND_KNEE;
            else if (req_any_foot_active) desired = rsma_pkg::KIND_FEET;
            else desired = rsma_pkg::KIND_NONE;
         end
         rsma_pkg::POSTURE_STANDING:
            desired = req_any_foot_active ? rsma_pkg::KIND_FEET : rsma_pkg::KIND_NONE;
         rsma_pkg::POSTURE_TRANSITION: begin
            if (req_any_foot_active && req_any_knee_active) desired = rsma_pkg::KIND_MIXED;
            else if (req_any_foot_active) desired = rsma_pkg::KIND_FEET;
            else desired = support_ff;
         end
         default:
            desired = req_any_knee_active ? rsma_pkg::KIND_KNEE : rsma_pkg::KIND_NONE;
      endcase
   end

   // Saturating timer sums and the confidence ramp.
   always_comb begin
      dwell_sum   = {1'b0, dwell_ff} + {{(rsma_pkg::TIME_W-rsma_pkg::DT_W+1){1'b0}},
                                        req_frame_time};
      release_sum = {1'b0, release_ff} + {{(rsma_pkg::TIME_W-rsma_pkg::DT_W+1){1'b0}},
                                          req_frame_time};
      release_sat = release_sum[rsma_pkg::TIME_W] ? '1 : release_sum[rsma_pkg::TIME_W-1:0];
      conf_sum    = {1'b0, conf_ff} + {1'b0, req_frame_time};
      hold        = (req_posture_mode == rsma_pkg::POSTURE_TRANSITION) ?
                    transition_hold_ff : release_time_ff;
   end

   // Anchor update for one frame.
   always_comb begin
      support_in = support_ff;
      active_in  = active_ff;
      conf_in    = conf_ff;
      dwell_in   = dwell_ff;
      release_in = release_ff;
      latch_pose = 1'b0;
      if (desired == support_ff) begin
         if (desired == rsma_pkg::KIND_NONE) begin
            active_in  = 1'b0;
            conf_in    = '0;
            dwell_in   = '0;
            release_in = '0;
         end else begin
            dwell_in   = dwell_sum[rsma_pkg::TIME_W] ? '1 : dwell_sum[rsma_pkg::TIME_W-1:0];
            release_in = '0;
            conf_in    = (conf_sum > {1'b0, rsma_pkg::CONF_ONE}) ?
                         rsma_pkg::CONF_ONE : conf_sum[rsma_pkg::CONF_W-1:0];
         end
      end else begin
         release_in = release_sat;
         if (release_sat >= {{(rsma_pkg::TIME_W-rsma_pkg::HOLD_W){1'b0}}, hold}) begin
            support_in = desired;
            latch_pose = 1'b1;
            active_in  = (desired != rsma_pkg::KIND_NONE);
            dwell_in   = '0;
            release_in = '0;
            conf_in    = (desired == rsma_pkg::KIND_NONE) ? '0 : rsma_pkg::CONF_RESTART;
         end
      end
   end

   // Response valid: set by a request transfer, cleared by a response transfer.
   always_comb begin
      if (req_xfer) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   // State registers: the anchor state updates only on a request transfer, the valid flag on every clock.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         support_ff   <= rsma_pkg::KIND_NONE;
         active_ff    <= 1'b0;
         conf_ff      <= '0;
         dwell_ff     <= '0;
         release_ff   <= '0;
         pos_x_ff     <= '0;
         pos_y_ff     <= '0;
         pos_z_ff     <= '0;
         quat_w_ff    <= '0;
         quat_x_ff    <= '0;
         quat_y_ff    <= '0;
         quat_z_ff    <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_xfer) begin
            support_ff <= support_in;
            active_ff  <= active_in;
            conf_ff    <= conf_in;
            dwell_ff   <= dwell_in;
            release_ff <= release_in;
            if (latch_pose) begin
               pos_x_ff  <= req_root_pos_x;
               pos_y_ff  <= req_root_pos_y;
               pos_z_ff  <= req_root_pos_z;
               quat_w_ff <= req_root_quat_w;
               quat_x_ff <= req_root_quat_x;
               quat_y_ff <= req_root_quat_y;
               quat_z_ff <= req_root_quat_z;
            end
         end
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_support_kind      = support_ff;
   assign rsp_anchor_on         = active_ff;
   assign rsp_anchor_confidence = conf_ff;
   assign rsp_anchor_dwell      = dwell_ff;
   assign rsp_anchor_pos_x      = pos_x_ff;
   assign rsp_anchor_pos_y      = pos_y_ff;
   assign rsp_anchor_pos_z      = pos_z_ff;
   assign rsp_anchor_quat_w     = quat_w_ff;
   assign rsp_anchor_quat_x     = quat_x_ff;
   assign rsp_anchor_quat_y     = quat_y_ff;
   assign rsp_anchor_quat_z     = quat_z_ff;

   // An active anchor always has a support type and at least restart confidence.
   `RSMA_ASSERT_IMP(a_active_has_kind, active_ff,
                    support_ff != rsma_pkg::KIND_NONE && conf_ff >= rsma_pkg::CONF_RESTART)
   // No support type means no confidence.
   `RSMA_ASSERT_IMP(a_none_no_conf, support_ff == rsma_pkg::KIND_NONE, conf_ff == '0)
   // Confidence never climbs above one.
   `RSMA_ASSERT_IMP(a_conf_cap, rsp_valid_ff, conf_ff <= rsma_pkg::CONF_ONE)
   // Every request transfer leaves a response pending.
   `RSMA_ASSERT_NXT(a_req_gives_rsp, req_xfer, rsp_valid_ff)

endmodule
`default_nettype wire

// File: bench/testbench.sv
// Self-checking bench for the root support mode arbiter: directed and random frames,
// register writes between phases, random request gaps and random response back-pressure.
// Depends on rsma_pkg and root_support_mode_arbiter.
`timescale 1ns / 100ps
module testbench;

   // Free postures have no names in the package.
   localparam logic [rsma_pkg::POSTURE_W-1:0] POSTURE_FREE_LO = 3'd6;
   localparam logic [rsma_pkg::POSTURE_W-1:0] POSTURE_FREE_HI = 3'd7;
   localparam int LONG_HOLD      = 300;
   localparam int QUIET_LIMIT    = 4000;
   localparam int REPORT_LIMIT   = 10;
   localparam int DWELL_RUN      = 40;

   typedef struct packed {
      logic [rsma_pkg::POSTURE_W-1:0] posture;
      logic                           feet;
      logic                           knees;
      logic [rsma_pkg::DT_W-1:0]      dt;
      logic [rsma_pkg::POS_W-1:0]     pos_x, pos_y, pos_z;
      logic [rsma_pkg::QUAT_W-1:0]    qw, qx, qy, qz;
   } frame_type;

   typedef struct packed {
      rsma_pkg::kind_type                 kind;
      logic                               on;
      logic [rsma_pkg::CONF_W-1:0]        conf;
      logic [rsma_pkg::TIME_W-1:0]        dwell;
      logic signed [rsma_pkg::POS_W-1:0]  pos_x, pos_y, pos_z;
      logic signed [rsma_pkg::QUAT_W-1:0] qw, qx, qy, qz;
   } anchor_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                            csr_valid = 1'b0;
   logic                            csr_ready;
   logic [rsma_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [rsma_pkg::HOLD_W-1:0]     csr_data = '0;

   logic                            req_valid = 1'b0;
   logic                            req_ready;
   logic [rsma_pkg::POSTURE_W-1:0]  req_posture_mode = '0;
   logic                            req_any_foot_active = 1'b0;
   logic                            req_any_knee_active = 1'b0;
   logic [rsma_pkg::DT_W-1:0]       req_frame_time = '0;
   logic [rsma_pkg::POS_W-1:0]      req_root_pos_x = '0, req_root_pos_y = '0;
   logic [rsma_pkg::POS_W-1:0]      req_root_pos_z = '0;
   logic [rsma_pkg::QUAT_W-1:0]     req_root_quat_w = '0, req_root_quat_x = '0;
   logic [rsma_pkg::QUAT_W-1:0]     req_root_quat_y = '0, req_root_quat_z = '0;

   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   logic [rsma_pkg::KIND_W-1:0]     rsp_support_kind;
   logic                            rsp_anchor_on;
   logic [rsma_pkg::CONF_W-1:0]     rsp_anchor_confidence;
   logic [rsma_pkg::TIME_W-1:0]     rsp_anchor_dwell;
   logic signed [rsma_pkg::POS_W-1:0]  rsp_anchor_pos_x, rsp_anchor_pos_y, rsp_anchor_pos_z;
   logic signed [rsma_pkg::QUAT_W-1:0] rsp_anchor_quat_w, rsp_anchor_quat_x;
   logic signed [rsma_pkg::QUAT_W-1:0] rsp_anchor_quat_y, rsp_anchor_quat_z;

   // Frames waiting to be offered and anchor states waiting to come back.
   frame_type  frames_pending[$];
   anchor_type anchor_expect[$];
   frame_type  frame_on_bus;
   anchor_type anchor_seen;
   anchor_type anchor_wanted;

   // Predicted block state and hold registers.
   anchor_type                  anchor_state = '0;
   logic [rsma_pkg::TIME_W-1:0] release_accum = '0;
   logic [rsma_pkg::HOLD_W-1:0] release_time_cfg = rsma_pkg::RELEASE_TIME_RESET;
   logic [rsma_pkg::HOLD_W-1:0] transition_hold_cfg = rsma_pkg::TRANSITION_HOLD_RESET;

   // Idling controls (the percentages set per phase by the stimulus process) and counters.
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int send_gap = 0;
   int recv_stall = 0;
   int long_holds_asked = 0;
   int long_holds_done = 0;
   int mismatch_count = 0;
   int quiet_cycles = 0;

   root_support_mode_arbiter dut (
      .clock                 (clock),
      .reset                 (reset),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_data              (csr_data),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_posture_mode      (req_posture_mode),
      .req_any_foot_active   (req_any_foot_active),
      .req_any_knee_active   (req_any_knee_active),
      .req_frame_time        (req_frame_time),
      .req_root_pos_x        (req_root_pos_x),
      .req_root_pos_y        (req_root_pos_y),
      .req_root_pos_z        (req_root_pos_z),
      .req_root_quat_w       (req_root_quat_w),
      .req_root_quat_x       (req_root_quat_x),
      .req_root_quat_y       (req_root_quat_y),
      .req_root_quat_z       (req_root_quat_z),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_support_kind      (rsp_support_kind),
      .rsp_anchor_on         (rsp_anchor_on),
      .rsp_anchor_confidence (rsp_anchor_confidence),
      .rsp_anchor_dwell      (rsp_anchor_dwell),
      .rsp_anchor_pos_x      (rsp_anchor_pos_x),
      .rsp_anchor_pos_y      (rsp_anchor_pos_y),
      .rsp_anchor_pos_z      (rsp_anchor_pos_z),
      .rsp_anchor_quat_w     (rsp_anchor_quat_w),
      .rsp_anchor_quat_x     (rsp_anchor_quat_x),
      .rsp_anchor_quat_y     (rsp_anchor_quat_y),
      .rsp_anchor_quat_z     (rsp_anchor_quat_z)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Timers stick at all ones instead of wrapping.
   function automatic logic [rsma_pkg::TIME_W-1:0] sat_time_add(
         input logic [rsma_pkg::TIME_W-1:0] a, input logic [rsma_pkg::DT_W-1:0] b);
      logic [rsma_pkg::TIME_W:0] sum;
      sum = {1'b0, a} + {{(rsma_pkg::TIME_W-rsma_pkg::DT_W+1){1'b0}}, b};
      return sum[rsma_pkg::TIME_W] ? '1 : sum[rsma_pkg::TIME_W-1:0];
   endfunction

   // Advances the predicted support and anchor by one frame and returns the new state.
   function automatic anchor_type advance_support(input frame_type f);
      rsma_pkg::kind_type          wanted;
      logic [rsma_pkg::TIME_W-1:0] hold;
      logic [rsma_pkg::CONF_W:0]   conf_sum;
      case (f.posture)
         rsma_pkg::POSTURE_SEATED: wanted = rsma_pkg::KIND_SEAT;
         rsma_pkg::POSTURE_RECLINED: wanted = rsma_pkg::KIND_REST;
         rsma_pkg::POSTURE_KNEELING, rsma_pkg::POSTURE_CROUCHING: begin
            if (f.feet && f.knees) wanted = rsma_pkg::KIND_MIXED;
            else if (f.knees) wanted = rsma_pkg::KIND_KNEE;
            else if (f.feet) wanted = rsma_pkg::KIND_FEET;
            else wanted = rsma_pkg::KIND_NONE;
         end
         rsma_pkg::POSTURE_STANDING:
            wanted = f.feet ? rsma_pkg::KIND_FEET : rsma_pkg::KIND_NONE;
         // With no feet down the transition posture keeps whatever is held.
         rsma_pkg::POSTURE_TRANSITION: begin
            if (f.feet && f.knees) wanted = rsma_pkg::KIND_MIXED;
            else if (f.feet) wanted = rsma_pkg::KIND_FEET;
            else wanted = anchor_state.kind;
         end
         default: wanted = f.knees ? rsma_pkg::KIND_KNEE : rsma_pkg::KIND_NONE;
      endcase

      if (wanted == anchor_state.kind) begin
         release_accum = '0;
         if (wanted == rsma_pkg::KIND_NONE) begin
            // Agreement on no support drops the anchor but keeps the pose.
            anchor_state.on = 1'b0;
            anchor_state.conf = '0;
            anchor_state.dwell = '0;
         end else begin
            conf_sum = {1'b0, anchor_state.conf} + {1'b0, f.dt};
            anchor_state.conf = (conf_sum > {1'b0, rsma_pkg::CONF_ONE}) ?
                                rsma_pkg::CONF_ONE : conf_sum[rsma_pkg::CONF_W-1:0];
            anchor_state.dwell = sat_time_add(anchor_state.dwell, f.dt);
         end
      end else begin
         hold = (f.posture == rsma_pkg::POSTURE_TRANSITION) ? {8'd0, transition_hold_cfg}
                                                            : {8'd0, release_time_cfg};
         release_accum = sat_time_add(release_accum, f.dt);
         // Once the hold is reached the new type is taken and the pose latched.
         if (release_accum >= hold) begin
            anchor_state.kind = wanted;
            anchor_state.on = (wanted != rsma_pkg::KIND_NONE);
            anchor_state.conf = (wanted == rsma_pkg::KIND_NONE) ? '0 : rsma_pkg::CONF_RESTART;
            anchor_state.dwell = '0;
            release_accum = '0;
            anchor_state.pos_x = f.pos_x;
            anchor_state.pos_y = f.pos_y;
            anchor_state.pos_z = f.pos_z;
            anchor_state.qw = f.qw;
            anchor_state.qx = f.qx;
            anchor_state.qy = f.qy;
            anchor_state.qz = f.qz;
         end
      end
      return anchor_state;
   endfunction

   function automatic string describe_anchor(input anchor_type a);
      return $sformatf({"kind=%0d on=%0d conf=%0d dwell=%0d pos=(%0d,%0d,%0d)",
                        " quat=(%0d,%0d,%0d,%0d)"},
                       a.kind, a.on, a.conf, a.dwell, a.pos_x, a.pos_y, a.pos_z,
                       a.qw, a.qx, a.qy, a.qz);
   endfunction

   task automatic note_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) $display("mismatch: %s", what);
   endtask

   // A frame with the given posture and timing and a random root pose.
   function automatic frame_type stance(input logic [rsma_pkg::POSTURE_W-1:0] posture,
                                        input logic feet, input logic knees,
                                        input logic [rsma_pkg::DT_W-1:0] dt);
      frame_type f;
      f.posture = posture;
      f.feet = feet;
      f.knees = knees;
      f.dt = dt;
      f.pos_x = $urandom;
      f.pos_y = $urandom;
      f.pos_z = $urandom;
      f.qw = 16'($urandom_range(0, 16'hFFFF));
      f.qx = 16'($urandom_range(0, 16'hFFFF));
      f.qy = 16'($urandom_range(0, 16'hFFFF));
      f.qz = 16'($urandom_range(0, 16'hFFFF));
      return f;
   endfunction

   function automatic frame_type with_pose(input frame_type f,
                                           input logic [rsma_pkg::POS_W-1:0] p,
                                           input logic [rsma_pkg::QUAT_W-1:0] q);
      f.pos_x = p;
      f.pos_y = p;
      f.pos_z = p;
      f.qw = q;
      f.qx = q;
      f.qy = q;
      f.qz = q;
      return f;
   endfunction

   // Mostly runs of one posture so that holds expire and types switch; some runs are noise.
   task automatic queue_random_frames(input int count);
      logic [rsma_pkg::POSTURE_W-1:0] posture;
      logic                           feet, knees, noisy;
      logic [rsma_pkg::DT_W-1:0]      dt;
      int                             run_len;
      while (count > 0) begin
         run_len = $urandom_range(1, 24);
         noisy = ($urandom_range(0, 4) == 0);
         posture = 3'($urandom_range(0, 7));
         feet = 1'($urandom_range(0, 1));
         knees = 1'($urandom_range(0, 1));
         repeat (run_len) begin
            if (noisy) begin
               posture = 3'($urandom_range(0, 7));
               feet = 1'($urandom_range(0, 1));
               knees = 1'($urandom_range(0, 1));
            end
            case ($urandom_range(0, 7))
               0: dt = '0;
               1: dt = '1;
               2, 3: dt = 16'($urandom_range(0, 16'hFFFF));
               default: dt = 16'($urandom_range(0, 16'h1000));
            endcase
            frames_pending.push_back(stance(posture, feet, knees, dt));
            count--;
         end
      end
   endtask

   task automatic write_csr(input logic [rsma_pkg::CSR_IDX_W-1:0] idx,
                            input logic [rsma_pkg::HOLD_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         rsma_pkg::CSR_RELEASE_TIME: release_time_cfg = value;
         rsma_pkg::CSR_TRANSITION_HOLD: transition_hold_cfg = value;
         default: ;
      endcase
   endtask

   // Waits until every frame is through and every expected state has come back.
   task automatic settle();
      while (frames_pending.size() != 0 || req_valid || anchor_expect.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic wait_frames_offered();
      while (frames_pending.size() != 0) @(posedge clock);
   endtask

   // Frame driver: predicts on each transfer, then offers the next frame or idles.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && req_ready) anchor_expect.push_back(advance_support(frame_on_bus));
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (frames_pending.size() != 0) begin
               frame_on_bus = frames_pending.pop_front();
               req_valid <= 1'b1;
               req_posture_mode <= frame_on_bus.posture;
               req_any_foot_active <= frame_on_bus.feet;
               req_any_knee_active <= frame_on_bus.knees;
               req_frame_time <= frame_on_bus.dt;
               req_root_pos_x <= frame_on_bus.pos_x;
               req_root_pos_y <= frame_on_bus.pos_y;
               req_root_pos_z <= frame_on_bus.pos_z;
               req_root_quat_w <= frame_on_bus.qw;
               req_root_quat_x <= frame_on_bus.qx;
               req_root_quat_y <= frame_on_bus.qy;
               req_root_quat_z <= frame_on_bus.qz;
               if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct)
                  send_gap = $urandom_range(1, 18);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: checks each transfer against the oldest expectation and
   // drives ready with random stalls and the occasional long hold-off.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_stall = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            anchor_seen = {rsp_support_kind, rsp_anchor_on, rsp_anchor_confidence,
                           rsp_anchor_dwell, rsp_anchor_pos_x, rsp_anchor_pos_y,
                           rsp_anchor_pos_z, rsp_anchor_quat_w, rsp_anchor_quat_x,
                           rsp_anchor_quat_y, rsp_anchor_quat_z};
            if (anchor_expect.size() == 0) begin
               note_mismatch({"unexpected response ", describe_anchor(anchor_seen)});
            end else begin
               anchor_wanted = anchor_expect.pop_front();
               if (anchor_seen !== anchor_wanted)
                  note_mismatch({"expected ", describe_anchor(anchor_wanted),
                                 " got ", describe_anchor(anchor_seen)});
            end
         end
         if (recv_stall > 0) begin
            recv_stall--;
            rsp_ready <= 1'b0;
         end else if (long_holds_done != long_holds_asked) begin
            long_holds_done++;
            recv_stall = LONG_HOLD - 1;
            rsp_ready <= 1'b0;
         end else if (recv_idle_pct > 0 && $urandom_range(0, 99) < recv_idle_pct) begin
            recv_stall = $urandom_range(0, 17);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Watchdog on cycles without any transfer.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("testbench: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Stimulus: phases separated by full drains, with register writes in between.
   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed frames at the reset hold times: every posture, every support type,
      // pending and completed switches, clearing on none and pose extremes.
      send_idle_pct = 30;
      recv_idle_pct = 8;
      frames_pending.push_back(with_pose(stance(rsma_pkg::POSTURE_STANDING, 1'b0, 1'b0,
                                                16'd0), '0, '0));
      frames_pending.push_back(with_pose(stance(rsma_pkg::POSTURE_SEATED, 1'b0, 1'b0,
                                                16'hFFFF), 32'h7FFF_FFFF, 16'h7FFF));
      frames_pending.push_back(stance(rsma_pkg::POSTURE_SEATED, 1'b1, 1'b1, 16'hFFFF));
      frames_pending.push_back(stance(rsma_pkg::POSTURE_RECLINED, 1'b0, 1'b0, 16'd100));
      frames_pending.push_back(with_pose(stance(rsma_pkg::POSTURE_RECLINED, 1'b0, 1'b0,
                                                16'd16284), 32'h8000_0000, 16'h8000));
      frames_pending.push_back(with_pose(stance(rsma_pkg::POSTURE_KNEELING, 1'b1, 1'b1,
                                                16'hFFFF), '1, '1));
      frames_pending.push_back(stance(rsma_pkg::POSTURE_CROUCHING, 1'b0, 1'b1, 16'hFFFF));
      frames_pending.push_back(stance(rsma_pkg::POSTURE_KNEELING, 1'b1, 1'b0, 16'hFFFF));
      frames_pending.push_back(with_pose(stance(rsma_pkg::POSTURE_CROUCHING, 1'b0, 1'b0,
                                                16'hFFFF), '0, '0));
      frames_pending.push_back(stance(rsma_pkg::POSTURE_CROUCHING, 1'b0, 1'b0, 16'd500));
      frames_pending.push_back(stance(rsma_pkg::POSTURE_TRANSITION, 1'b0, 1'b1, 16'hFFFF));
      frames_pending.push_back(stance(rsma_pkg::POSTURE_TRANSITION, 1'b1, 1'b0, 16'd20000));
      frames_pending.push_back(stance(rsma_pkg::POSTURE_TRANSITION, 1'b1, 1'b0, 16'd20000));
      frames_pending.push_back(stance(rsma_pkg::POSTURE_TRANSITION, 1'b1, 1'b1, 16'hFFFF));
      frames_pending.push_back(stance(rsma_pkg::POSTURE_TRANSITION, 1'b0, 1'b1, 16'd3000));
      frames_pending.push_back(stance(rsma_pkg::POSTURE_TRANSITION, 1'b0, 1'b0, 16'd3000));
      frames_pending.push_back(stance(POSTURE_FREE_LO, 1'b0, 1'b1, 16'hFFFF));
      frames_pending.push_back(stance(POSTURE_FREE_HI, 1'b1, 1'b0, 16'hFFFF));
      frames_pending.push_back(stance(POSTURE_FREE_HI, 1'b0, 1'b1, 16'hFFFF));
      frames_pending.push_back(stance(rsma_pkg::POSTURE_STANDING, 1'b1, 1'b1, 16'hFFFF));
      frames_pending.push_back(stance(rsma_pkg::POSTURE_STANDING, 1'b0, 1'b0, 16'd8000));
      frames_pending.push_back(stance(rsma_pkg::POSTURE_STANDING, 1'b1, 1'b0, 16'd8000));
      settle();

      // Zero hold times: any differing frame switches at once.
      write_csr(rsma_pkg::CSR_RELEASE_TIME, '0);
      write_csr(rsma_pkg::CSR_TRANSITION_HOLD, '0);
      send_idle_pct = 20;
      recv_idle_pct = 5;
      queue_random_frames(100);
      settle();

      // Long hold times, the transition hold at its largest, with a long receiver
      // hold-off while frames keep coming.
      write_csr(rsma_pkg::CSR_RELEASE_TIME, 24'h1F_FFFF);
      write_csr(rsma_pkg::CSR_TRANSITION_HOLD, '1);
      send_idle_pct = 10;
      recv_idle_pct = 4;
      long_holds_asked++;
      repeat (40) frames_pending.push_back(stance(rsma_pkg::POSTURE_SEATED, 1'b0, 1'b0,
                                                  16'hFFFF));
      repeat (40) frames_pending.push_back(stance(rsma_pkg::POSTURE_RECLINED, 1'b1, 1'b1,
                                                  16'hFFFF));
      queue_random_frames(40);
      settle();

      // Random hold times in the range that random frames can reach, with stretches
      // of heavy idling alternating with none.
      write_csr(rsma_pkg::CSR_RELEASE_TIME, 24'($urandom_range(0, 24'h3FFFF)));
      write_csr(rsma_pkg::CSR_TRANSITION_HOLD, 24'($urandom_range(0, 24'h3FFFF)));
      for (int chunk = 0; chunk < 6; chunk++) begin
         send_idle_pct = chunk[0] ? 0 : 35;
         recv_idle_pct = chunk[0] ? 0 : 10;
         queue_random_frames(50);
         wait_frames_offered();
      end
      settle();

      // Last part without idling: back to the reset holds and a seated run that
      // grows the dwell timer and caps confidence, then a final random stretch.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      while (send_gap != 0 || recv_stall != 0) @(posedge clock);
      write_csr(rsma_pkg::CSR_RELEASE_TIME, rsma_pkg::RELEASE_TIME_RESET);
      write_csr(rsma_pkg::CSR_TRANSITION_HOLD, rsma_pkg::TRANSITION_HOLD_RESET);
      repeat (DWELL_RUN)
         frames_pending.push_back(stance(rsma_pkg::POSTURE_SEATED, 1'($urandom_range(0, 1)),
                                         1'($urandom_range(0, 1)), 16'hFFFF));
      queue_random_frames(100);
      settle();
      repeat (8) @(posedge clock);

      if (anchor_expect.size() != 0)
         note_mismatch($sformatf("%0d expected responses never arrived", anchor_expect.size()));
      if (mismatch_count == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule
